// File: rtl/cbfd_pkg.sv
// Shared types and constants for the cubic B-spline forward-difference block.
package cbfd_pkg;

  localparam int COORD_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int MAX_SEGMENTS_DEF = 63;
  localparam int SEG_W            = 6;
  localparam logic [SEG_W-1:0] SEG_RESET = 6'd16;

  typedef struct packed {
    logic [COORD_WIDTH_DEF-1:0] p0_x;
    logic [COORD_WIDTH_DEF-1:0] p0_y;
    logic [COORD_WIDTH_DEF-1:0] p0_z;
    logic [COORD_WIDTH_DEF-1:0] p1_x;
    logic [COORD_WIDTH_DEF-1:0] p1_y;
    logic [COORD_WIDTH_DEF-1:0] p1_z;
    logic [COORD_WIDTH_DEF-1:0] p2_x;
    logic [COORD_WIDTH_DEF-1:0] p2_y;
    logic [COORD_WIDTH_DEF-1:0] p2_z;
    logic [COORD_WIDTH_DEF-1:0] p3_x;
    logic [COORD_WIDTH_DEF-1:0] p3_y;
    logic [COORD_WIDTH_DEF-1:0] p3_z;
  } cbfd_in_t;

  typedef struct packed {
    logic [COORD_WIDTH_DEF-1:0] out_x;
    logic [COORD_WIDTH_DEF-1:0] out_y;
    logic [COORD_WIDTH_DEF-1:0] out_z;
    logic [SEG_W-1:0]           step_index;
    logic                       last;
  } cbfd_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_EMIT
  } cbfd_state_t;

endpackage

// File: rtl/cbfd_front.sv
// Front end: clamps the step count, computes per-axis spline coefficients and queues items.
module cbfd_front #(
  parameter int COORD_WIDTH  = 32,
  parameter int MAX_SEGMENTS = 63,
  parameter int CW           = COORD_WIDTH + 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cbfd_pkg::SEG_W-1:0]        seg_cfg,
  input  logic [3*COORD_WIDTH-1:0]          p0,
  input  logic [3*COORD_WIDTH-1:0]          p1,
  input  logic [3*COORD_WIDTH-1:0]          p2,
  input  logic [3*COORD_WIDTH-1:0]          p3,
  input  logic                              pop,
  output logic                              q_valid,
  output logic                              q_full,
  output logic [cbfd_pkg::SEG_W-1:0]        q_n,
  output logic [3*CW-1:0]                   q_a,
  output logic [3*CW-1:0]                   q_b,
  output logic [3*CW-1:0]                   q_c,
  output logic [3*CW-1:0]                   q_d
);
  import cbfd_pkg::*;

  localparam int QD = 2;

  logic [SEG_W-1:0] n_cl;
  logic [3*CW-1:0]  a_w, b_w, c_w, d_w;

  logic [SEG_W-1:0] mem_n [QD];
  logic [3*CW-1:0]  mem_a [QD];
  logic [3*CW-1:0]  mem_b [QD];
  logic [3*CW-1:0]  mem_c [QD];
  logic [3*CW-1:0]  mem_d [QD];
  logic             wp, rp;
  logic [1:0]       cnt;
  logic             push;

  always_comb begin
    n_cl = seg_cfg;
    if (n_cl == '0) n_cl = SEG_W'(1);
    if (n_cl > SEG_W'(MAX_SEGMENTS)) n_cl = SEG_W'(MAX_SEGMENTS);
  end

  // coefficients scaled by six
  always_comb begin
    logic signed [CW-1:0] s0, s1, s2, s3;
    for (int ax = 0; ax < 3; ax++) begin
      s0 = CW'($signed(p0[ax*COORD_WIDTH +: COORD_WIDTH]));
      s1 = CW'($signed(p1[ax*COORD_WIDTH +: COORD_WIDTH]));
      s2 = CW'($signed(p2[ax*COORD_WIDTH +: COORD_WIDTH]));
      s3 = CW'($signed(p3[ax*COORD_WIDTH +: COORD_WIDTH]));
      a_w[ax*CW +: CW] = -s0 + 3*s1 - 3*s2 + s3;
      b_w[ax*CW +: CW] = 3*s0 - 6*s1 + 3*s2;
      c_w[ax*CW +: CW] = 3*s2 - 3*s0;
      d_w[ax*CW +: CW] = s0 + 4*s1 + s2;
    end
  end

  assign push    = start && !q_full;
  assign q_full  = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_n = mem_n[rp];
  assign q_a = mem_a[rp];
  assign q_b = mem_b[rp];
  assign q_c = mem_c[rp];
  assign q_d = mem_d[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_n[wp] <= n_cl;
      mem_a[wp] <= a_w;
      mem_b[wp] <= b_w;
      mem_c[wp] <= c_w;
      mem_d[wp] <= d_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(pop && !q_valid))
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) push && !pop |=> q_valid)
    else $error("pushed item not visible");
endmodule

// File: rtl/cbfd_back.sv
// Back end: forward-difference setup, iterative rounding divide and point emission.
module cbfd_back #(
  parameter int COORD_WIDTH = 32,
  parameter int CW          = COORD_WIDTH + 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  logic [cbfd_pkg::SEG_W-1:0]   q_n,
  input  logic [3*CW-1:0]              q_a,
  input  logic [3*CW-1:0]              q_b,
  input  logic [3*CW-1:0]              q_c,
  input  logic [3*CW-1:0]              q_d,
  output logic                         pop,
  output logic                         idle,
  output logic                         res_strobe,
  output cbfd_pkg::cbfd_out_t          res
);
  import cbfd_pkg::*;

  // d0 reaches |D| * 63^3 < 2^(CW+18); 22 extra bits leave room for the running sums
  localparam int DW  = CW + 22;
  localparam int DEN_W = 22;               // 2*6*63^3 < 2^22
  localparam int QW  = DW + 1;
  localparam int QCW = $clog2(QW + 1);

  cbfd_state_t state, state_next;
  logic [SEG_W-1:0] n, k;
  logic [1:0]  ax;
  logic [QCW-1:0] bitc;
  logic signed [DW-1:0] d0 [3], d1 [3], d2 [3], d3 [3];
  logic [DEN_W-1:0] den2;
  logic [QW-1:0]  num, quo;
  logic [DEN_W:0] rem;
  logic           neg;
  logic [COORD_WIDTH-1:0] pt [3];
  logic [11:0]    n2;
  logic [17:0]    n3;

  // setup uses 3 steps: n^3, then differences, then the first divider load (n^2 is taken in idle)
  logic [1:0] sstep;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_valid) state_next = ST_SETUP;
      ST_SETUP: if (sstep == 2'd2) state_next = ST_DIV;
      ST_DIV:   if (ax == 2'd2 && bitc == '0) state_next = ST_EMIT;
      ST_EMIT:  state_next = (k == n) ? ST_IDLE : ST_DIV;
      default:  state_next = ST_IDLE;
    endcase
  end

  // hold the queue entry until its coefficients have been taken
  always_comb begin
    pop  = (state == ST_SETUP) && (sstep == 2'd1);
    idle = (state == ST_IDLE) && !q_valid;
  end

  function automatic logic [QW-1:0] mag_of(input logic signed [DW-1:0] v,
                                           input logic [DEN_W-1:0] dd);
    logic signed [DW+1:0] t;
    t = (DW+2)'(v) * 2 + (DW+2)'($signed({1'b0, dd}) >>> 1);
    return t[DW+1] ? QW'(-t) : QW'(t);
  endfunction

  function automatic logic tneg(input logic signed [DW-1:0] v,
                                input logic [DEN_W-1:0] dd);
    logic signed [DW+1:0] t;
    t = (DW+2)'(v) * 2 + (DW+2)'($signed({1'b0, dd}) >>> 1);
    return t[DW+1];
  endfunction

  always_ff @(posedge clk) begin
    logic [DEN_W:0] r2;
    logic [QW-1:0]  qf;
    logic [QW:0]    qr;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          n <= q_n; sstep <= 2'd0;
          n2 <= 12'(q_n) * 12'(q_n);
        end
        k <= '0;
      end
      ST_SETUP: begin
        sstep <= sstep + 2'd1;
        if (sstep == 2'd0) n3 <= 18'(n2) * 18'(n);
        if (sstep == 2'd1) begin
          den2 <= DEN_W'(n3 * 12);
          for (int i = 0; i < 3; i++) begin
            d3[i] <= DW'($signed(q_a[i*CW +: CW])) * 6;
            d2[i] <= DW'($signed(q_a[i*CW +: CW])) * 6
                     + DW'($signed(q_b[i*CW +: CW])) * $signed({1'b0, n, 1'b0});
            d1[i] <= DW'($signed(q_a[i*CW +: CW]))
                     + DW'($signed(q_b[i*CW +: CW])) * $signed({1'b0, n})
                     + DW'($signed(q_c[i*CW +: CW])) * $signed({1'b0, n2});
            d0[i] <= DW'($signed(q_d[i*CW +: CW])) * $signed({1'b0, n3});
          end
        end
        if (sstep == 2'd2) begin
          ax <= 2'd0; bitc <= QCW'(QW);
          num <= mag_of(d0[0], den2); neg <= tneg(d0[0], den2);
          quo <= '0; rem <= '0;
        end
      end
      ST_DIV: begin
        if (bitc != '0) begin
          r2 = {rem[DEN_W-1:0], num[QW-1]};
          num <= {num[QW-2:0], 1'b0};
          if (r2 >= {1'b0, den2}) begin
            rem <= r2 - {1'b0, den2}; quo <= {quo[QW-2:0], 1'b1};
          end else begin
            rem <= r2; quo <= {quo[QW-2:0], 1'b0};
          end
          bitc <= bitc - QCW'(1);
        end else begin
          // finish axis: round magnitude away for negatives, saturate
          if (neg) begin
            qr = {1'b0, quo} + (QW+1)'(rem != '0);
            if (qr >= (QW+1)'(1) << (COORD_WIDTH-1))
              pt[ax] <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
            else pt[ax] <= COORD_WIDTH'(-qr);
          end else begin
            qf = quo;
            if (qf > QW'({(COORD_WIDTH-1){1'b1}}))
              pt[ax] <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
            else pt[ax] <= COORD_WIDTH'(qf);
          end
          if (ax != 2'd2) begin
            ax <= ax + 2'd1; bitc <= QCW'(QW); quo <= '0; rem <= '0;
            num <= mag_of(d0[ax+2'd1], den2); neg <= tneg(d0[ax+2'd1], den2);
          end
        end
      end
      ST_EMIT: begin
        for (int i = 0; i < 3; i++) begin
          d0[i] <= d0[i] + d1[i];
          d1[i] <= d1[i] + d2[i];
          d2[i] <= d2[i] + d3[i];
        end
        k <= k + SEG_W'(1);
        ax <= 2'd0; bitc <= QCW'(QW); quo <= '0; rem <= '0;
        num <= mag_of(d0[0] + d1[0], den2); neg <= tneg(d0[0] + d1[0], den2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) res_strobe <= 1'b0;
    else res_strobe <= (state == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      res.out_x <= pt[0]; res.out_y <= pt[1]; res.out_z <= pt[2];
      res.step_index <= k; res.last <= (k == n);
    end
  end

  assert property (@(posedge clk) disable iff (rst) res_strobe |-> res.step_index <= n)
    else $error("step index beyond segment count");
  assert property (@(posedge clk) disable iff (rst) pop |=> state == ST_SETUP)
    else $error("popped item not started");
  assert property (@(posedge clk) disable iff (rst) res_strobe && res.last |-> state == ST_IDLE)
    else $error("last point without return to idle");
endmodule

// File: rtl/cubic_bspline_forward_difference.sv
// Top level of the cubic B-spline forward-difference point generator.
// Each item of four control points yields segments+1 points, one strobed cycle each. A point
// takes one pass of the shared bit-serial rounding divider per axis plus an emit state, and
// an item also passes the idle and setup states to pick up its queue entry and set up the
// differences; the divider loop sets the rate. A two-entry
// queue lets the next item be accepted while the current one is being emitted. The receiver
// cannot stall: each result is valid for its one strobe cycle only.
module cubic_bspline_forward_difference #(
  parameter int FRAC_BITS    = cbfd_pkg::FRAC_BITS_DEF,
  parameter int MAX_SEGMENTS = cbfd_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  cbfd_pkg::cbfd_in_t         in_item,
  output logic                       done,
  output cbfd_pkg::cbfd_out_t        result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cbfd_pkg::SEG_W-1:0] cfg_data
);
  import cbfd_pkg::*;

  localparam int COORD_WIDTH = COORD_WIDTH_DEF;
  localparam int CW = COORD_WIDTH + 4 + (FRAC_BITS - FRAC_BITS);

  logic [SEG_W-1:0] seg;
  logic q_valid, q_full, pop, idle;
  logic [SEG_W-1:0] q_n;
  logic [3*CW-1:0] q_a, q_b, q_c, q_d;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) seg <= SEG_RESET;
    else if (cfg_valid && cfg_ready) seg <= cfg_data;
  end

  assign busy = q_full;

  cbfd_front #(.COORD_WIDTH(COORD_WIDTH), .MAX_SEGMENTS(MAX_SEGMENTS), .CW(CW)) u_front (
    .clk, .rst, .start, .seg_cfg(seg),
    .p0({in_item.p0_z, in_item.p0_y, in_item.p0_x}),
    .p1({in_item.p1_z, in_item.p1_y, in_item.p1_x}),
    .p2({in_item.p2_z, in_item.p2_y, in_item.p2_x}),
    .p3({in_item.p3_z, in_item.p3_y, in_item.p3_x}),
    .pop, .q_valid, .q_full, .q_n, .q_a, .q_b, .q_c, .q_d
  );

  cbfd_back #(.COORD_WIDTH(COORD_WIDTH), .CW(CW)) u_back (
    .clk, .rst, .q_valid, .q_n, .q_a, .q_b, .q_c, .q_d,
    .pop, .idle, .res_strobe(done), .res(result)
  );

  assert property (@(posedge clk) disable iff (rst) done |-> !idle || result.last)
    else $error("result while back end idle");
  assert property (@(posedge clk) disable iff (rst) busy |-> !idle)
    else $error("queue full with idle back end");
  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");
endmodule

// File: test/cubic_bspline_forward_difference_test.sv
// Testbench for the cubic B-spline forward-difference point generator.
module cubic_bspline_forward_difference_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbfd_pkg::*;

  localparam int  LIMIT_CYCLES = 2000000;
  localparam int  SETTLE       = 400;
  localparam int  N_DIRECTED   = 14;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    cbfd_in_t   pts;
    bit         known;
    logic [31:0] kx, ky, kz;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cbfd_in_t    in_item = '0;
  logic        done;
  cbfd_out_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [SEG_W-1:0] cfg_data = '0;

  cbfd_out_t   pending_points[$];
  logic [SEG_W-1:0] seg_cur;
  int          fails = 0;
  int          cycles = 0;
  row_t        dir_rows[N_DIRECTED];

  cubic_bspline_forward_difference u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycles,
               pending_points.size());
      $display("cubic_bspline_forward_difference_test failed");
      $finish;
    end
  end

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %h got %h", what, want, got);
    fails++;
  endtask

  // round num/den to nearest, ties up, then saturate to 32 bits signed
  function automatic logic [31:0] round_q16(wide_t num, wide_t den);
    wide_t t, d2, q;
    t  = num * 2 + den;
    d2 = den * 2;
    q  = t / d2;
    if ((t % d2) != 0 && t < 0) q = q - 1;
    if (q > 128'sd2147483647) return 32'h7fffffff;
    if (q < -128'sd2147483648) return 32'h80000000;
    return q[31:0];
  endfunction

  task automatic predict_curve(cbfd_in_t p, logic [SEG_W-1:0] seg);
    logic [31:0] c[4][3];
    wide_t d0[3], d1[3], d2[3], d3[3];
    wide_t wa, wb, wc, wd, wn, den;
    longint a0, a1, a2, a3;
    logic [31:0] o[3];
    int n;
    cbfd_out_t pt;
    c = '{'{p.p0_x, p.p0_y, p.p0_z}, '{p.p1_x, p.p1_y, p.p1_z},
          '{p.p2_x, p.p2_y, p.p2_z}, '{p.p3_x, p.p3_y, p.p3_z}};
    n = (seg == 0) ? 1 : int'(seg);
    wn = n;
    den = 6 * wn * wn * wn;
    for (int ax = 0; ax < 3; ax++) begin
      a0 = $signed(c[0][ax]); a1 = $signed(c[1][ax]);
      a2 = $signed(c[2][ax]); a3 = $signed(c[3][ax]);
      wa = -a0 + 3 * a1 - 3 * a2 + a3;
      wb = 3 * a0 - 6 * a1 + 3 * a2;
      wc = 3 * a2 - 3 * a0;
      wd = a0 + 4 * a1 + a2;
      d3[ax] = 6 * wa;
      d2[ax] = d3[ax] + 2 * wb * wn;
      d1[ax] = wa + wb * wn + wc * wn * wn;
      d0[ax] = wd * wn * wn * wn;
    end
    for (int k = 0; k <= n; k++) begin
      for (int ax = 0; ax < 3; ax++) begin
        o[ax] = round_q16(d0[ax], den);
        d0[ax] = d0[ax] + d1[ax];
        d1[ax] = d1[ax] + d2[ax];
        d2[ax] = d2[ax] + d3[ax];
      end
      pt.out_x = o[0]; pt.out_y = o[1]; pt.out_z = o[2];
      pt.step_index = k[SEG_W-1:0];
      pt.last = (k == n);
      pending_points.push_back(pt);
    end
  endtask

  // flat control net: every point of the curve equals the control value
  task automatic push_flat(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [SEG_W-1:0] seg);
    int n;
    cbfd_out_t pt;
    n = (seg == 0) ? 1 : int'(seg);
    for (int k = 0; k <= n; k++) begin
      pt.out_x = x; pt.out_y = y; pt.out_z = z;
      pt.step_index = k[SEG_W-1:0];
      pt.last = (k == n);
      pending_points.push_back(pt);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_points.size() == 0) begin
        report("unexpected point", '0, result.out_x);
      end else begin
        cbfd_out_t w;
        w = pending_points.pop_front();
        if (result.out_x !== w.out_x) report("out_x", w.out_x, result.out_x);
        if (result.out_y !== w.out_y) report("out_y", w.out_y, result.out_y);
        if (result.out_z !== w.out_z) report("out_z", w.out_z, result.out_z);
        if (result.step_index !== w.step_index)
          report("step_index", 32'(w.step_index), 32'(result.step_index));
        if (result.last !== w.last) report("last", 32'(w.last), 32'(result.last));
      end
    end
  end

  // hold start high until the block takes the item; start stays high afterward
  task automatic issue(row_t r);
    start   <= 1'b1;
    in_item <= r.pts;
    do @(posedge clk); while (busy);
    if (r.known) push_flat(r.kx, r.ky, r.kz, seg_cur);
    else predict_curve(r.pts, seg_cur);
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_segments(logic [SEG_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    seg_cur = v;
  endtask

  function automatic row_t flat_row(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    row_t r;
    r.pts = {x, y, z, x, y, z, x, y, z, x, y, z};
    r.known = 1'b1; r.kx = x; r.ky = y; r.kz = z;
    return r;
  endfunction

  function automatic row_t pred_row(cbfd_in_t p);
    row_t r;
    r.pts = p; r.known = 1'b0; r.kx = '0; r.ky = '0; r.kz = '0;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(int mode, logic [31:0] base);
    case (mode)
      0: return $urandom;
      1: return base + 32'($urandom_range(0, 8192)) - 32'd4096;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h00000000;
          default: return 32'hffffffff;
        endcase
      end
    endcase
  endfunction

  function automatic row_t rand_row;
    int mode;
    logic [31:0] base;
    logic [31:0] f[12];
    cbfd_in_t p;
    mode = $urandom_range(0, 9);
    base = $urandom;
    if (mode == 9) return flat_row($urandom, $urandom, $urandom);
    for (int i = 0; i < 12; i++)
      f[i] = rand_coord(mode < 5 ? 0 : (mode < 8 ? 1 : 2), base);
    p = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
    return pred_row(p);
  endfunction

  // sender works in bursts with random gaps
  task automatic run_items(int count);
    int burst;
    burst = $urandom_range(1, 6);
    for (int i = 0; i < count; i++) begin
      issue(rand_row());
      burst--;
      if (burst == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 300)) @(posedge clk);
        burst = $urandom_range(1, 6);
      end
    end
  endtask

  initial begin
    logic [SEG_W-1:0] segs[13];
    seg_cur = SEG_RESET;
    dir_rows[0]  = flat_row(32'h0, 32'h0, 32'h0);
    dir_rows[1]  = flat_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    dir_rows[2]  = flat_row(32'h80000000, 32'h80000000, 32'h80000000);
    dir_rows[3]  = flat_row(32'hffffffff, 32'h00000001, 32'h00010000);
    dir_rows[4]  = flat_row(32'haaaaaaaa, 32'h55555555, 32'hfffe0000);
    dir_rows[5]  = pred_row({4{32'h7fffffff, 32'h80000000, 32'h00000000}});
    dir_rows[6]  = pred_row({32'h80000000, 32'h80000000, 32'h80000000,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h80000000, 32'h80000000, 32'h80000000,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    dir_rows[7]  = pred_row({32'h7fffffff, 32'h0, 32'h80000000,
                             32'h80000000, 32'h0, 32'h7fffffff,
                             32'h7fffffff, 32'h0, 32'h80000000,
                             32'h80000000, 32'h0, 32'h7fffffff});
    dir_rows[8]  = pred_row({32'h0, 32'h0, 32'h0, 32'h00010000, 32'h00020000,
                             32'h00030000, 32'h00020000, 32'h00040000, 32'h00060000,
                             32'h00030000, 32'h00060000, 32'h00090000});
    dir_rows[9]  = pred_row({32'h00000001, 32'hffffffff, 32'h00000003,
                             32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                             32'h00000002, 32'hfffffffe, 32'h00000005});
    dir_rows[10] = pred_row({12{32'h00000001}} ^ {6{32'h0, 32'h00000001}});
    dir_rows[11] = pred_row({12{32'h55555555}} ^ {6{32'hffffffff, 32'h0}});
    dir_rows[12] = pred_row({32'hffff0000, 32'h00010000, 32'h7fff0000,
                             32'h80010000, 32'h12345678, 32'hedcba987,
                             32'h0000ffff, 32'hffff0001, 32'h40000000,
                             32'hc0000000, 32'h3fffffff, 32'hc0000001});
    dir_rows[13] = flat_row(32'h00008000, 32'hffff8000, 32'h00000000);
    segs = '{6'd1, 6'd0, 6'd63, 6'd2, 6'd5, 6'd3, 6'd1, 6'd4, 6'd8, 6'd7, 6'd6, 6'd2, 6'd16};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) issue(dir_rows[i]);
    // wait out every point before any new item
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      logic [SEG_W-1:0] s;
      s = (ph >= 6 && ph < 12 && $urandom_range(0, 1)) ? 6'($urandom_range(1, 8)) : segs[ph];
      write_segments(s);
      if (ph == 1) issue(flat_row(32'h7fffffff, 32'h80000000, 32'h1));
      run_items((s >= 32) ? 3 : 13);
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) begin
      $display("cubic_bspline_forward_difference_test passed");
    end else begin
      $display("cubic_bspline_forward_difference_test failed");
    end
    $finish;
  end

endmodule

// File: cubic_bspline_forward_difference.f
rtl/cbfd_pkg.sv
rtl/cbfd_front.sv
rtl/cbfd_back.sv
rtl/cubic_bspline_forward_difference.sv
test/cubic_bspline_forward_difference_test.sv
